// ===== src/hsv2rgb_pkg.sv =====
// Shared types, constants and widths for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

  localparam int unsigned CH_W            = 8;
  localparam int unsigned FRAC_W          = 8;
  localparam int unsigned H6_W            = 11;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] brightness;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_out_t;

  // Color wheel sector, hue*6 >> 8.
  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  // Classified work item handed from front to back.
  typedef struct packed {
    logic              gray;
    sector_t           sector;
    logic [FRAC_W-1:0] frac;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   bri;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/hsv_to_rgb_pixel_core.sv =====
// Top level of the HSV to RGB pixel converter: front end, work queue, back end.
// Path from an input transfer to out_valid with an empty pipe: input register,
//   queue slot, two multiply stages, output register.
// Throughput: one pixel per clock; the back end's three register stages all
//   advance together whenever the output register is empty or being drained.
// Reset: synchronous, active low; clears valid flags, queue pointers and queue count only.
module hsv_to_rgb_pixel_core #(
  parameter int unsigned QUEUE_DEPTH = hsv2rgb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsv2rgb_pkg::pix_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsv2rgb_pkg::pix_out_t out_data
);

  // Front to queue: a work item moves whenever the front holds one and the queue has a free slot.
  logic                 q_push;
  hsv2rgb_pkg::work_t   q_wdata;

  // Queue to back: the back end pops whenever its stages advance and the queue is not empty.
  logic                 q_pop;
  hsv2rgb_pkg::work_t   q_rdata;
  hsv2rgb_pkg::q_stat_t q_stat;

  // Classify: sector, hue fraction and the gray (zero saturation) flag.
  hsv2rgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (!q_stat.full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Decouple the two halves so either side may stall on its own.
  hsv2rgb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  // Compute the p, q, t and v levels and pick channels by sector.
  hsv2rgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_stat.empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("work queue overflow");

  // Back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("work queue underflow");

  // Reset drops any result in the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled front end only ever waits on a full queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_stat.full)
    else $error("input stalled with room in queue");

endmodule

// ===== src/hsv2rgb_front.sv =====
// Front end: takes pixels, splits hue into sector and fraction, feeds the queue.
module hsv2rgb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsv2rgb_pkg::pix_in_t in_data,
  input  logic                 q_ready,
  output logic                 q_push,
  output hsv2rgb_pkg::work_t   q_data
);

  logic                              valid_r;
  logic                              valid_nxt;
  hsv2rgb_pkg::work_t                item_r;
  hsv2rgb_pkg::work_t                item_nxt;
  logic [hsv2rgb_pkg::H6_W-1:0]      h6;

  assign q_push   = valid_r && q_ready;
  assign in_ready = !valid_r || q_ready;
  assign q_data   = item_r;

  always_comb begin
    h6              = hsv2rgb_pkg::H6_W'(in_data.hue) * hsv2rgb_pkg::H6_W'(6);
    item_nxt.gray   = (in_data.saturation == '0);
    item_nxt.sector = hsv2rgb_pkg::sector_t'(h6[hsv2rgb_pkg::H6_W-1:hsv2rgb_pkg::FRAC_W]);
    item_nxt.frac   = h6[hsv2rgb_pkg::FRAC_W-1:0];
    item_nxt.sat    = in_data.saturation;
    item_nxt.bri    = in_data.brightness;
    valid_nxt       = in_valid ? 1'b1 : (valid_r && !q_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== src/hsv2rgb_queue.sv =====
// Small FIFO of classified work items between front and back.
module hsv2rgb_queue #(
  parameter int unsigned DEPTH = hsv2rgb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hsv2rgb_pkg::work_t   push_data,
  input  logic                 pop,
  output hsv2rgb_pkg::work_t   pop_data,
  output hsv2rgb_pkg::q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hsv2rgb_pkg::work_t entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/hsv2rgb_back.sv =====
// Back end: three-stage pipeline of level arithmetic, sector select and output register.
module hsv2rgb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  hsv2rgb_pkg::work_t    q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsv2rgb_pkg::pix_out_t out_data
);

  localparam int unsigned CW = hsv2rgb_pkg::CH_W;

  logic                       adv;

  // Stage 1: S*F, S*(256-F), V*(256-S)
  logic                       v1_r;
  logic                       gray1_r;
  hsv2rgb_pkg::sector_t       sec1_r;
  logic [CW-1:0]              bri1_r;
  logic [15:0]                sf1_r;
  logic [15:0]                sfc1_r;
  logic [15:0]                pv1_r;
  logic [16:0]                sfc_full;
  logic [16:0]                pv_full;

  // Stage 2: V*(65536-S*F), V*(65536-S*(256-F)), p
  logic                       v2_r;
  logic                       gray2_r;
  hsv2rgb_pkg::sector_t       sec2_r;
  logic [CW-1:0]              bri2_r;
  logic [24:0]                qv2_r;
  logic [24:0]                tv2_r;
  logic [CW-1:0]              p2_r;
  logic [16:0]                qm;
  logic [16:0]                tm;
  logic [23:0]                p_scaled;

  // Stage 3: levels and select
  logic                       out_valid_r;
  hsv2rgb_pkg::pix_out_t      out_r;
  hsv2rgb_pkg::pix_out_t      out_nxt;
  logic [32:0]                q_scaled;
  logic [32:0]                t_scaled;
  logic [15:0]                vv_scaled;
  logic [CW-1:0]              lv_q;
  logic [CW-1:0]              lv_t;
  logic [CW-1:0]              lv_v;

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sfc_full = 17'(q_data.sat) * (17'd256 - 17'(q_data.frac));
    pv_full  = 17'(q_data.bri) * (17'd256 - 17'(q_data.sat));
    qm       = 17'h10000 - 17'(sf1_r);
    tm       = 17'h10000 - 17'(sfc1_r);
    p_scaled = {pv1_r, 8'b0} - 24'(pv1_r);
  end

  always_comb begin
    q_scaled  = {qv2_r, 8'b0} - 33'(qv2_r);
    t_scaled  = {tv2_r, 8'b0} - 33'(tv2_r);
    vv_scaled = {bri2_r, 8'b0} - 16'(bri2_r);
    lv_q      = q_scaled[31:24];
    lv_t      = t_scaled[31:24];
    lv_v      = vv_scaled[15:8];
    out_nxt   = '0;
    if (gray2_r) begin
      out_nxt = '{red: lv_v, green: lv_v, blue: lv_v};
    end else begin
      unique case (sec2_r)
        hsv2rgb_pkg::SEC_RED_YEL: out_nxt = '{red: lv_v, green: lv_t, blue: p2_r};
        hsv2rgb_pkg::SEC_YEL_GRN: out_nxt = '{red: lv_q, green: lv_v, blue: p2_r};
        hsv2rgb_pkg::SEC_GRN_CYN: out_nxt = '{red: p2_r, green: lv_v, blue: lv_t};
        hsv2rgb_pkg::SEC_CYN_BLU: out_nxt = '{red: p2_r, green: lv_q, blue: lv_v};
        hsv2rgb_pkg::SEC_BLU_MAG: out_nxt = '{red: lv_t, green: p2_r, blue: lv_v};
        hsv2rgb_pkg::SEC_MAG_RED: out_nxt = '{red: lv_v, green: p2_r, blue: lv_q};
        default:                  out_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gray1_r <= q_data.gray;
      sec1_r  <= q_data.sector;
      bri1_r  <= q_data.bri;
      sf1_r   <= 16'(q_data.sat) * 16'(q_data.frac);
      sfc1_r  <= sfc_full[15:0];
      pv1_r   <= pv_full[15:0];

      gray2_r <= gray1_r;
      sec2_r  <= sec1_r;
      bri2_r  <= bri1_r;
      qv2_r   <= 25'(bri1_r) * 25'(qm);
      tv2_r   <= 25'(bri1_r) * 25'(tm);
      p2_r    <= p_scaled[23:16];

      out_r   <= out_nxt;
    end
  end

endmodule

// ===== sim/hsv_to_rgb_pixel_core_tb.sv =====
// Self-checking testbench for the HSV to RGB pixel converter core.
module hsv_to_rgb_pixel_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PIXELS = 600;
  localparam int unsigned IDLE_PCT      = 15;
  // Transfer counts between which neither side idles.
  localparam int unsigned QUIET_FROM    = 250;
  localparam int unsigned QUIET_TO      = 400;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned MAX_PRINTED   = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  hsv2rgb_pkg::pix_in_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  hsv2rgb_pkg::pix_out_t out_data;

  // Pixels waiting to be offered, and colors predicted for accepted pixels.
  hsv2rgb_pkg::pix_in_t  pending_pixels[$];
  hsv2rgb_pkg::pix_out_t expected_colors[$];

  int unsigned pixels_sent;
  int unsigned colors_checked;
  int unsigned mismatch_count;
  int unsigned gray_count;
  int unsigned sector_hits[6];

  hsv_to_rgb_pixel_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Exact fixed-point conversion: every level is scaled by 255 and truncated.
  function automatic hsv2rgb_pkg::pix_out_t convert_pixel(hsv2rgb_pkg::pix_in_t px);
    logic [10:0]           h6;
    longint unsigned       vb;
    longint unsigned       sb;
    longint unsigned       fb;
    logic [7:0]            lv_v;
    logic [7:0]            lv_p;
    logic [7:0]            lv_q;
    logic [7:0]            lv_t;
    hsv2rgb_pkg::pix_out_t rgb;
    vb   = 64'(px.brightness);
    sb   = 64'(px.saturation);
    h6   = 11'(px.hue) * 11'd6;
    fb   = 64'(h6[7:0]);
    lv_v = 8'((vb * 255) >> 8);
    lv_p = 8'((vb * (256 - sb) * 255) >> 16);
    lv_q = 8'((vb * (65536 - sb * fb) * 255) >> 24);
    lv_t = 8'((vb * (65536 - sb * (256 - fb)) * 255) >> 24);
    rgb  = '0;
    if (sb == 0) begin
      // No saturation: gray at the value level.
      rgb.red   = lv_v;
      rgb.green = lv_v;
      rgb.blue  = lv_v;
    end else begin
      case (hsv2rgb_pkg::sector_t'(h6[10:8]))
        hsv2rgb_pkg::SEC_RED_YEL: begin
          rgb.red = lv_v; rgb.green = lv_t; rgb.blue = lv_p;
        end
        hsv2rgb_pkg::SEC_YEL_GRN: begin
          rgb.red = lv_q; rgb.green = lv_v; rgb.blue = lv_p;
        end
        hsv2rgb_pkg::SEC_GRN_CYN: begin
          rgb.red = lv_p; rgb.green = lv_v; rgb.blue = lv_t;
        end
        hsv2rgb_pkg::SEC_CYN_BLU: begin
          rgb.red = lv_p; rgb.green = lv_q; rgb.blue = lv_v;
        end
        hsv2rgb_pkg::SEC_BLU_MAG: begin
          rgb.red = lv_t; rgb.green = lv_p; rgb.blue = lv_v;
        end
        hsv2rgb_pkg::SEC_MAG_RED: begin
          rgb.red = lv_v; rgb.green = lv_p; rgb.blue = lv_q;
        end
        default: rgb = '0;
      endcase
    end
    return rgb;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] color %0d: %s", $realtime, colors_checked, what);
    end
  endtask

  // Driver: on a transfer, predict the color; then offer the next pixel unless idling.
  // Valid only drops or moves on when the current pixel has been taken.
  always @(posedge clk) begin
    logic    hold_off;
    logic [10:0] h6;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_colors.push_back(convert_pixel(in_data));
        h6 = 11'(in_data.hue) * 11'd6;
        if (in_data.saturation == '0) gray_count++;
        else sector_hits[h6[10:8]]++;
        pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        hold_off = !(pixels_sent >= QUIET_FROM && pixels_sent < QUIET_TO) &&
                   ($urandom_range(0, 99) < IDLE_PCT);
        if (pending_pixels.size() > 0 && !hold_off) begin
          in_valid <= 1'b1;
          in_data  <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each transfer with the oldest prediction, then pick next ready.
  always @(posedge clk) begin
    hsv2rgb_pkg::pix_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("unexpected color %h with nothing predicted", out_data));
        end else begin
          want = expected_colors.pop_front();
          if (out_data.red !== want.red)
            report_mismatch($sformatf("red %h, want %h", out_data.red, want.red));
          if (out_data.green !== want.green)
            report_mismatch($sformatf("green %h, want %h", out_data.green, want.green));
          if (out_data.blue !== want.blue)
            report_mismatch($sformatf("blue %h, want %h", out_data.blue, want.blue));
        end
        colors_checked++;
      end
      out_ready <= (colors_checked >= QUIET_FROM && colors_checked < QUIET_TO) ||
                   ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus and end of run.
  initial begin
    hsv2rgb_pkg::pix_in_t px;
    int unsigned pick;
    // Hues on each side of every sector boundary, plus both ends of the wheel.
    byte unsigned edge_hues[12] = '{0, 42, 43, 85, 86, 127, 128, 170, 171, 213, 214, 255};

    rst_n          = 1'b0;
    pixels_sent    = 0;
    colors_checked = 0;
    mismatch_count = 0;
    gray_count     = 0;
    foreach (sector_hits[i]) sector_hits[i] = 0;

    // Directed part: corners, gray, sector boundaries at full color, then two mid-level pixels.
    pending_pixels.push_back('{hue: 8'h00, saturation: 8'h00, brightness: 8'h00});
    pending_pixels.push_back('{hue: 8'hff, saturation: 8'hff, brightness: 8'hff});
    pending_pixels.push_back('{hue: 8'h00, saturation: 8'hff, brightness: 8'hff});
    pending_pixels.push_back('{hue: 8'hff, saturation: 8'h00, brightness: 8'hff});
    pending_pixels.push_back('{hue: 8'h5a, saturation: 8'h00, brightness: 8'h80});
    pending_pixels.push_back('{hue: 8'h80, saturation: 8'h01, brightness: 8'hff});
    pending_pixels.push_back('{hue: 8'h40, saturation: 8'hff, brightness: 8'h00});
    pending_pixels.push_back('{hue: 8'h2a, saturation: 8'h01, brightness: 8'h01});
    foreach (edge_hues[i]) begin
      pending_pixels.push_back('{hue: edge_hues[i], saturation: 8'hff, brightness: 8'hff});
    end
    pending_pixels.push_back('{hue: 8'h55, saturation: 8'h80, brightness: 8'hc0});
    pending_pixels.push_back('{hue: 8'hd6, saturation: 8'h7f, brightness: 8'h3f});

    // Random part: mostly uniform, with gray, boundary hues and extreme levels mixed in.
    repeat (RANDOM_PIXELS) begin
      px   = hsv2rgb_pkg::pix_in_t'(24'($urandom()));
      pick = $urandom_range(0, 15);
      if (pick < 2) px.saturation = 8'h00;
      else if (pick < 4) px.hue = edge_hues[$urandom_range(0, 11)];
      else if (pick == 4) px.brightness = $urandom_range(0, 1) ? 8'hff : 8'h00;
      else if (pick == 5) px.saturation = $urandom_range(0, 1) ? 8'hff : 8'h01;
      pending_pixels.push_back(px);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every pixel has been taken and every color checked; look
    // between edges so the driver and monitor have settled.
    @(negedge clk);
    while (pending_pixels.size() > 0 || in_valid || expected_colors.size() > 0) begin
      @(negedge clk);
    end
    // Let any stray output show up before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels, checked %0d colors, %0d gray inputs.",
             pixels_sent, colors_checked, gray_count);
    $display("Colored pixels per sector: %0d %0d %0d %0d %0d %0d.",
             sector_hits[0], sector_hits[1], sector_hits[2],
             sector_hits[3], sector_hits[4], sector_hits[5]);
    if (mismatch_count == 0 && expected_colors.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Timeout with %0d colors still predicted.", expected_colors.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
